[sv/dcc_halfbit_packet_framer_assert.svh]
// Assertion macros for the DCC half-bit packet framer.
// Used by dhpf_framer and the top level in this folder; no other dependencies.
`ifndef DCC_HALFBIT_PACKET_FRAMER_ASSERT_SVH
`define DCC_HALFBIT_PACKET_FRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define DHPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define DHPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DHPF_ASSERT_NOW(label, ante, cons, msg)
`define DHPF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[sv/dhpf_pkg.sv]
// Shared types and constants of the DCC half-bit packet framer.
// No dependencies; imported by every module of the block.
package dhpf_pkg;

  localparam int TICKS_W     = 16;
  localparam int BYTES_W     = 56;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ENABLE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRICT_MODE      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ONE_THRESHOLD_US = 2'd2;

  // Timing check modes
  localparam logic [1:0] STRICT_NONE       = 2'd0;
  localparam logic [1:0] STRICT_DECODER    = 2'd1;
  localparam logic [1:0] STRICT_CONTROLLER = 2'd2;

  localparam logic [10:0] RESET_ONE_THRESHOLD_US = 11'd80;
  localparam int          CLAMP_US               = 1200;
  localparam int          GLITCH_US              = 4;
  localparam logic [7:0]  PREAMBLE_MIN           = 8'd10;
  localparam logic [7:0]  PREAMBLE_MAX           = 8'd255;

  typedef struct packed {
    logic        filter_enable;
    logic [1:0]  strict_mode;
    logic [10:0] one_threshold_us;
  } cfg_t;

  // Edge history kept by the framer and needed by the classifier
  typedef struct packed {
    logic               seen;
    logic               last_pin;
    logic [TICKS_W-1:0] last_ticks;
  } edge_hist_t;

  typedef struct packed {
    logic               accept;
    logic               bit_val;
    logic               out_of_spec;
    logic [TICKS_W-1:0] ticks;
  } edge_info_t;

  typedef struct packed {
    logic               overlong;
    logic [2:0]         byte_count;
    logic [BYTES_W-1:0] packet_bytes;
    logic               packet_done;
    logic               accepted;
  } result_t;

endpackage

[sv/dhpf_edge_class.sv]
// Edge classifier: clamps the half-bit length, filters glitches, decides the
// half-bit value and checks timing limits. Depends on dhpf_pkg.
module dhpf_edge_class import dhpf_pkg::*; #(
  parameter int TICKS_PER_US = 2
) (
  input  logic [TICKS_W-1:0] half_bit_ticks,
  input  logic               pin_level,
  input  cfg_t               cfg,
  input  edge_hist_t         hist,
  output edge_info_t         info
);

  // All microsecond limits are compared in ticks: floor(t/T) < X <=> t < X*T
  localparam int MAX_TICKS    = CLAMP_US * TICKS_PER_US;
  localparam int GLITCH_TICKS = GLITCH_US * TICKS_PER_US;
  localparam int CTL0_LO      = 95 * TICKS_PER_US;
  localparam int CTL0_HI      = 9901 * TICKS_PER_US;
  localparam int CTL1_LO      = 55 * TICKS_PER_US;
  localparam int CTL1_HI      = 62 * TICKS_PER_US;
  localparam int CTL_DELTA    = 3 * TICKS_PER_US;
  localparam int DEC0_LO      = 90 * TICKS_PER_US;
  localparam int DEC0_HI      = 10001 * TICKS_PER_US;
  localparam int DEC1_LO      = 52 * TICKS_PER_US;
  localparam int DEC1_HI      = 65 * TICKS_PER_US;
  localparam int DEC_DELTA    = 6 * TICKS_PER_US;

  logic [TICKS_W-1:0] ticks_c;
  logic [TICKS_W-1:0] diff;
  logic [31:0]        t32;
  logic [31:0]        d32;
  logic [31:0]        thr_ticks;
  logic               bit_val;
  logic               ctl_bad;
  logic               dec_bad;

  assign ticks_c   = (32'(half_bit_ticks) > 32'(MAX_TICKS)) ? TICKS_W'(MAX_TICKS)
                                                            : half_bit_ticks;
  assign diff      = (ticks_c >= hist.last_ticks) ? ticks_c - hist.last_ticks
                                                  : hist.last_ticks - ticks_c;
  assign t32       = 32'(ticks_c);
  assign d32       = 32'(diff);
  assign thr_ticks = 32'(cfg.one_threshold_us) * 32'(TICKS_PER_US);
  assign bit_val   = t32 < thr_ticks;

  assign ctl_bad = bit_val
    ? (t32 < 32'(CTL1_LO) || t32 >= 32'(CTL1_HI) || d32 > 32'(CTL_DELTA))
    : (t32 < 32'(CTL0_LO) || t32 >= 32'(CTL0_HI));
  assign dec_bad = bit_val
    ? (t32 < 32'(DEC1_LO) || t32 >= 32'(DEC1_HI) || d32 > 32'(DEC_DELTA))
    : (t32 < 32'(DEC0_LO) || t32 >= 32'(DEC0_HI));

  always_comb begin
    info.accept  = !(cfg.filter_enable && hist.seen &&
                     (pin_level == hist.last_pin || t32 < 32'(GLITCH_TICKS)));
    info.bit_val = bit_val;
    info.ticks   = ticks_c;
    case (cfg.strict_mode)
      STRICT_CONTROLLER: info.out_of_spec = ctl_bad;
      STRICT_DECODER:    info.out_of_spec = dec_bad;
      default:           info.out_of_spec = 1'b0;
    endcase
  end

endmodule

[sv/dhpf_framer.sv]
// Bit pairing, preamble counting and byte framing state of the DCC framer.
// Depends on dhpf_pkg and the assertion header.
`include "dcc_halfbit_packet_framer_assert.svh"
module dhpf_framer import dhpf_pkg::*; #(
  parameter int PACKET_BUFFER_LENGTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       pin_level,
  input  logic       queue_full,
  input  edge_info_t info,
  output edge_hist_t hist,
  output result_t    res
);

  localparam logic [2:0] MAX_STORED = 3'(PACKET_BUFFER_LENGTH - 1);

  logic [7:0]         preamble_ones, preamble_ones_next;
  logic               in_packet, in_packet_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic [3:0]         bits_in_byte, bits_in_byte_next;
  logic [2:0]         bytes_stored, bytes_stored_next;
  logic [BYTES_W-1:0] packet_store, packet_store_next;
  logic [1:0]         startup_edges, startup_edges_next;
  logic               last_bit_value, last_bit_value_next;
  logic               last_pin, last_pin_next;
  logic [TICKS_W-1:0] last_ticks, last_ticks_next;
  logic               second_half, second_half_next;
  logic [7:0]         sb;
  logic [3:0]         bits_inc;

  assign hist.seen       = startup_edges != 2'd0;
  assign hist.last_pin   = last_pin;
  assign hist.last_ticks = last_ticks;

  assign sb       = {shift_byte[6:0], info.bit_val};
  assign bits_inc = bits_in_byte + 4'd1;

  always_comb begin
    preamble_ones_next  = preamble_ones;
    in_packet_next      = in_packet;
    shift_byte_next     = shift_byte;
    bits_in_byte_next   = bits_in_byte;
    bytes_stored_next   = bytes_stored;
    packet_store_next   = packet_store;
    startup_edges_next  = startup_edges;
    last_bit_value_next = last_bit_value;
    last_pin_next       = last_pin;
    last_ticks_next     = last_ticks;
    second_half_next    = second_half;
    res                 = '0;
    res.accepted        = info.accept;

    if (info.accept) begin
      last_pin_next   = pin_level;
      last_ticks_next = info.ticks;
      last_bit_value_next = info.bit_val;
      if (startup_edges < 2'd2) begin
        startup_edges_next = startup_edges + 2'd1;
      end else begin
        second_half_next = (info.bit_val != last_bit_value) ? 1'b0 : !second_half;
        if (second_half_next) begin
          // Drop a packet on a bit outside the timing limits
          if (info.out_of_spec && in_packet) begin
            in_packet_next     = 1'b0;
            preamble_ones_next = '0;
          end
          if (!in_packet_next) begin
            if (info.bit_val) begin
              if (preamble_ones_next < PREAMBLE_MAX) begin
                preamble_ones_next = preamble_ones_next + 8'd1;
              end
            end else if (preamble_ones_next < PREAMBLE_MIN) begin
              preamble_ones_next = '0;
            end else begin
              in_packet_next    = 1'b1;
              shift_byte_next   = '0;
              bits_in_byte_next = '0;
              bytes_stored_next = '0;
              packet_store_next = '0;
            end
          end else if (queue_full) begin
            in_packet_next     = 1'b0;
            preamble_ones_next = '0;
          end else if (bits_in_byte == 4'd8) begin
            // Separator bit: zero means another byte, one ends the packet
            if (!info.bit_val) begin
              bits_in_byte_next = '0;
            end else begin
              res.packet_done    = 1'b1;
              res.byte_count     = bytes_stored;
              res.packet_bytes   = packet_store;
              in_packet_next     = 1'b0;
              preamble_ones_next = 8'd1;
            end
          end else begin
            shift_byte_next   = sb;
            bits_in_byte_next = bits_inc;
            if (bits_inc == 4'd8) begin
              if (bytes_stored < MAX_STORED) begin
                for (int k = 0; k < 7; k++) begin
                  if (bytes_stored == 3'(k)) begin
                    packet_store_next[BYTES_W-1-8*k -: 8] = sb;
                  end
                end
                bytes_stored_next = bytes_stored + 3'd1;
              end else begin
                res.packet_done    = 1'b1;
                res.overlong       = 1'b1;
                res.byte_count     = bytes_stored;
                res.packet_bytes   = packet_store;
                in_packet_next     = 1'b0;
                preamble_ones_next = '0;
              end
              shift_byte_next = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_ones  <= '0;
      in_packet      <= 1'b0;
      shift_byte     <= '0;
      bits_in_byte   <= '0;
      bytes_stored   <= '0;
      packet_store   <= '0;
      startup_edges  <= '0;
      last_bit_value <= 1'b0;
      last_pin       <= 1'b0;
      last_ticks     <= '0;
      second_half    <= 1'b0;
    end else if (step) begin
      preamble_ones  <= preamble_ones_next;
      in_packet      <= in_packet_next;
      shift_byte     <= shift_byte_next;
      bits_in_byte   <= bits_in_byte_next;
      bytes_stored   <= bytes_stored_next;
      packet_store   <= packet_store_next;
      startup_edges  <= startup_edges_next;
      last_bit_value <= last_bit_value_next;
      last_pin       <= last_pin_next;
      last_ticks     <= last_ticks_next;
      second_half    <= second_half_next;
    end
  end

  // A rejected edge leaves the framing state untouched
  `DHPF_ASSERT_NEXT(a_reject_holds, step && !info.accept,
    $stable(preamble_ones) && $stable(in_packet) && $stable(second_half),
    "rejected edge changed framing state")
  `DHPF_ASSERT_NOW(a_packet_bytes_limit, in_packet,
    bits_in_byte <= 4'd8 && bytes_stored <= MAX_STORED,
    "byte framing counters out of range inside a packet")

endmodule

[sv/dcc_halfbit_packet_framer.sv]
// Top level of the DCC half-bit decoder and packet framer: stream ports,
// configuration registers, input and result registers.
// Depends on dhpf_pkg, dhpf_edge_class, dhpf_framer and the assertion header.
//
// Usage:
//   Feed one transaction per signal edge on s_axis: the half-bit length in
//   timer ticks, the pin level and the downstream queue-full flag. Every
//   transaction yields exactly one result transaction on m_axis, in order:
//   whether the edge was accepted, and any packet that finished on it.
//   The accepting edge loads the input register; the result register is
//   loaded from it once the result slot is free, and only then does the
//   result show on m_axis. Throughput is one edge per cycle while the
//   receiver does not stall: the classifier and framer state update form
//   one short combinational path between the two registers.
//   When the receiver stalls, the result register holds its transaction and
//   the input register still takes one more edge; s_axis_tready drops only
//   when both are full. Configuration writes land on cfg_wr_en and apply to
//   the next edge processed; write only while no edge is in flight.
//   Reset (rst, synchronous) empties both registers, clears all framing
//   state and loads filter_enable=1, strict_mode=1, one_threshold_us=80.
//   The first two accepted edges after reset only seed the edge history.
`include "dcc_halfbit_packet_framer_assert.svh"
module dcc_halfbit_packet_framer import dhpf_pkg::*; #(
  parameter int TICKS_PER_US         = 2,
  parameter int PACKET_BUFFER_LENGTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] half_bit_ticks, [16] pin_level, [17] queue_full, [23:18] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] accepted, [1] packet_done, [57:2] packet_bytes, [60:58] byte_count,
  // [61] overlong, [63:62] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t               cfg;
  logic               in_valid;
  logic [TICKS_W-1:0] in_ticks;
  logic               in_pin;
  logic               in_qfull;
  logic               out_valid;
  result_t            out_res;
  logic               advance;
  edge_hist_t         hist;
  edge_info_t         info;
  result_t            res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_enable    <= 1'b1;
      cfg.strict_mode      <= STRICT_DECODER;
      cfg.one_threshold_us <= RESET_ONE_THRESHOLD_US;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FILTER_ENABLE:    cfg.filter_enable    <= cfg_data[0];
        CFG_STRICT_MODE:      cfg.strict_mode      <= cfg_data[1:0];
        CFG_ONE_THRESHOLD_US: cfg.one_threshold_us <= cfg_data;
        default:              ;
      endcase
    end
  end

  // Advance the edge in the input register whenever the result slot frees
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ticks <= s_axis_tdata[15:0];
      in_pin   <= s_axis_tdata[16];
      in_qfull <= s_axis_tdata[17];
    end
  end

  dhpf_edge_class #(
    .TICKS_PER_US (TICKS_PER_US)
  ) u_edge_class (
    .half_bit_ticks (in_ticks),
    .pin_level      (in_pin),
    .cfg            (cfg),
    .hist           (hist),
    .info           (info)
  );

  dhpf_framer #(
    .PACKET_BUFFER_LENGTH (PACKET_BUFFER_LENGTH)
  ) u_framer (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .pin_level  (in_pin),
    .queue_full (in_qfull),
    .info       (info),
    .hist       (hist),
    .res        (res)
  );

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_res};

  `DHPF_ASSERT_NOW(a_done_needs_accept, out_valid && out_res.packet_done,
    out_res.accepted, "packet reported on a rejected edge")
  `DHPF_ASSERT_NOW(a_idle_fields_zero, out_valid && !out_res.packet_done,
    out_res.byte_count == 3'd0 && !out_res.overlong && out_res.packet_bytes == '0,
    "packet fields set without a finished packet")
  `DHPF_ASSERT_NOW(a_overlong_count, out_valid && out_res.overlong,
    out_res.packet_done && out_res.byte_count == 3'(PACKET_BUFFER_LENGTH - 1),
    "overlong packet with wrong byte count")
  `DHPF_ASSERT_NEXT(a_stall_keeps_input, in_valid && !advance,
    in_valid, "input edge lost while the result register was full")

endmodule

[sim/dcc_halfbit_packet_framer_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for dcc_halfbit_packet_framer: drives edge streams,
// predicts each result transaction and compares it field by field.
// Depends on dhpf_pkg and the RTL of the block.
module dcc_halfbit_packet_framer_tb;
  import dhpf_pkg::*;

  localparam int TICKS_PER_US = 2;
  localparam int PKT_BUF_LEN  = 8;
  localparam int QUIET_LIMIT  = 4000;

  // Timing windows of the half-bit checks, in microseconds
  localparam int CTRL_ZERO_MIN  = 95;
  localparam int CTRL_ZERO_MAX  = 9900;
  localparam int CTRL_ONE_MIN   = 55;
  localparam int CTRL_ONE_MAX   = 61;
  localparam int CTRL_ONE_DELTA = 3;
  localparam int DEC_ZERO_MIN   = 90;
  localparam int DEC_ZERO_MAX   = 10000;
  localparam int DEC_ONE_MIN    = 52;
  localparam int DEC_ONE_MAX    = 64;
  localparam int DEC_ONE_DELTA  = 6;

  // Strict mode code that the block treats as "no check"
  localparam logic [1:0] STRICT_UNUSED = 2'd3;

  // One edge as it travels on s_axis_tdata
  typedef struct packed {
    logic [5:0]         pad;
    logic               queue_full;
    logic               pin_level;
    logic [TICKS_W-1:0] ticks;
  } edge_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [15:0] half_bit_ticks, [16] pin_level, [17] queue_full, [23:18] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [0] accepted, [1] packet_done, [57:2] packet_bytes, [60:58] byte_count,
  // [61] overlong, [63:62] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  dcc_halfbit_packet_framer #(
    .TICKS_PER_US        (TICKS_PER_US),
    .PACKET_BUFFER_LENGTH(PKT_BUF_LEN)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Edges waiting to be sent, and reports predicted for every edge taken
  edge_word_t edge_q[$];
  result_t    report_q[$];

  int fail_cnt    = 0;
  int gen_count   = 0;
  int gen_limit   = 1000;
  int burst_left  = 0;
  int gap_left    = 0;
  int stall_mode  = 0;
  int stall_cnt   = 0;
  int quiet_cnt   = 0;
  logic gen_pin   = 1'b0;

  // Configuration as the framer sees it
  logic        cf_filter = 1'b1;
  logic [1:0]  cf_strict = STRICT_DECODER;
  logic [10:0] cf_thr    = RESET_ONE_THRESHOLD_US;

  // Framer state, all cleared by reset
  logic [7:0]         fr_preamble    = '0;
  logic               fr_in_pkt      = 1'b0;
  logic [7:0]         fr_shift       = '0;
  logic [3:0]         fr_nbits       = '0;
  logic [2:0]         fr_nbytes      = '0;
  logic [BYTES_W-1:0] fr_store       = '0;
  logic [1:0]         fr_startup     = '0;
  logic               fr_last_bit    = 1'b0;
  logic               fr_last_pin    = 1'b0;
  logic [TICKS_W-1:0] fr_last_ticks  = '0;
  logic               fr_second_half = 1'b0;

  result_t want_rep;
  result_t got_rep;

  function automatic logic timing_bad(input logic bitv, input int unsigned us,
                                      input int unsigned delta);
    if (cf_strict == STRICT_CONTROLLER) begin
      if (!bitv) return us < CTRL_ZERO_MIN || us > CTRL_ZERO_MAX;
      return us < CTRL_ONE_MIN || us > CTRL_ONE_MAX || delta > CTRL_ONE_DELTA;
    end
    if (cf_strict == STRICT_DECODER) begin
      if (!bitv) return us < DEC_ZERO_MIN || us > DEC_ZERO_MAX;
      return us < DEC_ONE_MIN || us > DEC_ONE_MAX || delta > DEC_ONE_DELTA;
    end
    return 1'b0;
  endfunction

  // Advance the framer by one edge and return the report it produces
  function automatic result_t decode_edge(input edge_word_t w);
    result_t     r;
    int unsigned ticks;
    int unsigned us;
    int unsigned diff;
    int unsigned delta;
    int          sh;
    logic        bitv;
    r = '0;
    r.accepted = 1'b1;
    ticks = w.ticks;
    if (ticks > CLAMP_US * TICKS_PER_US) ticks = CLAMP_US * TICKS_PER_US;
    us = ticks / TICKS_PER_US;
    // Glitch filter: same pin level or too short, once history exists
    if (cf_filter && fr_startup != 0 && (w.pin_level == fr_last_pin || us < GLITCH_US)) begin
      r.accepted = 1'b0;
      return r;
    end
    diff  = (ticks >= fr_last_ticks) ? ticks - fr_last_ticks : fr_last_ticks - ticks;
    delta = (diff + TICKS_PER_US - 1) / TICKS_PER_US;
    bitv  = (us < cf_thr);
    fr_last_pin   = w.pin_level;
    fr_last_ticks = ticks[TICKS_W-1:0];
    // The first two accepted edges only seed the history
    if (fr_startup < 2) begin
      fr_startup  = fr_startup + 2'd1;
      fr_last_bit = bitv;
      return r;
    end
    fr_second_half = (bitv != fr_last_bit) ? 1'b0 : ~fr_second_half;
    fr_last_bit    = bitv;
    if (fr_second_half) begin
      // A bad bit inside a packet drops the packet, then counts as preamble
      if (timing_bad(bitv, us, delta) && fr_in_pkt) begin
        fr_in_pkt   = 1'b0;
        fr_preamble = '0;
      end
      if (!fr_in_pkt) begin
        if (bitv) begin
          if (fr_preamble < PREAMBLE_MAX) fr_preamble = fr_preamble + 8'd1;
        end else if (fr_preamble < PREAMBLE_MIN) begin
          fr_preamble = '0;
        end else begin
          fr_in_pkt = 1'b1;
          fr_shift  = '0;
          fr_nbits  = '0;
          fr_nbytes = '0;
          fr_store  = '0;
        end
      end else if (w.queue_full) begin
        fr_in_pkt   = 1'b0;
        fr_preamble = '0;
      end else if (fr_nbits == 4'd8) begin
        // Separator bit: zero continues, one closes the packet
        if (!bitv) begin
          fr_nbits = '0;
        end else begin
          r.packet_done  = 1'b1;
          r.byte_count   = fr_nbytes;
          r.packet_bytes = fr_store;
          fr_in_pkt      = 1'b0;
          fr_preamble    = 8'd1;
        end
      end else begin
        fr_shift = {fr_shift[6:0], bitv};
        fr_nbits = fr_nbits + 4'd1;
        if (fr_nbits == 4'd8) begin
          if (fr_nbytes < PKT_BUF_LEN - 1) begin
            sh = 48 - 8 * int'(fr_nbytes);
            fr_store  = fr_store | ({48'd0, fr_shift} << sh);
            fr_nbytes = fr_nbytes + 3'd1;
          end else begin
            r.packet_done  = 1'b1;
            r.overlong     = 1'b1;
            r.byte_count   = fr_nbytes;
            r.packet_bytes = fr_store;
            fr_in_pkt      = 1'b0;
            fr_preamble    = '0;
          end
          fr_shift = '0;
        end
      end
    end
    return r;
  endfunction

  // Queue one raw edge; drop it once the phase budget is used up
  task automatic put_raw(input int unsigned ticks, input logic pin, input logic qf);
    edge_word_t w;
    if (gen_count >= gen_limit) return;
    w            = '0;
    w.ticks      = ticks[TICKS_W-1:0];
    w.pin_level  = pin;
    w.queue_full = qf;
    edge_q.push_back(w);
    gen_count++;
    gen_pin = pin;
  endtask

  // Queue one half-bit with the pin toggled; bad lengths break the controller timing windows
  task automatic put_half(input logic one, input logic bad, input logic qf);
    int unsigned us_v;
    if (bad)
      us_v = one ? $urandom_range(65, 75) : $urandom_range(80, 94);
    else if (one)
      us_v = ($urandom_range(0, 9) != 0) ? $urandom_range(57, 58) : $urandom_range(52, 64);
    else
      us_v = ($urandom_range(0, 9) != 0) ? $urandom_range(95, 160) : $urandom_range(161, 1300);
    put_raw(us_v * TICKS_PER_US + $urandom_range(0, TICKS_PER_US - 1), ~gen_pin, qf);
  endtask

  // A bit is two half-bits; broken bits may go bad, flag queue full or lose a half
  task automatic put_bit(input logic b, input logic broken);
    repeat (2) begin
      if (!(broken && $urandom_range(0, 59) == 0))
        put_half(b, broken && $urandom_range(0, 39) == 0,
                 broken && $urandom_range(0, 39) == 0);
    end
  endtask

  task automatic put_packet(input int npre, input int nbytes, input logic broken);
    repeat (npre) put_bit(1'b1, broken);
    put_bit(1'b0, broken);
    for (int i = 0; i < nbytes; i++) begin
      repeat (8) put_bit(1'($urandom_range(0, 1)), broken);
      put_bit(i == nbytes - 1, broken);
    end
  endtask

  task automatic put_noise(input int n);
    repeat (n) begin
      put_raw(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Mostly clean packets with random content, the rest damaged packets and noise
  task automatic put_sequence();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      put_packet($urandom_range(9, 14),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4),
                 1'b0);
    else if (r < 85)
      put_packet($urandom_range(10, 14), $urandom_range(1, 5), 1'b1);
    else
      put_noise($urandom_range(1, 6));
  endtask

  // Hold until every queued edge is taken and every report has come back
  task automatic drain_wait();
    do @(posedge clk);
    while (edge_q.size() != 0 || report_q.size() != 0 || s_axis_tvalid);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_FILTER_ENABLE:    cf_filter = val[0];
      CFG_STRICT_MODE:      cf_strict = val[1:0];
      CFG_ONE_THRESHOLD_US: cf_thr    = val[10:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_cnt++;
    end
  endtask

  // Sender: bursts of random length with random gaps. A transaction that is
  // offered stays on the bus unchanged until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        report_q.push_back(decode_edge(edge_word_t'(s_axis_tdata)));
        void'(edge_q.pop_front());
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (edge_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= edge_q[0];
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            // long stretch with no gaps
            burst_left = $urandom_range(30, 60);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(0, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switch between randomly chosen stall patterns
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_cnt  = 0;
      stall_mode = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt % 128 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 99) >= 35);
        2:       m_axis_tready <= (stall_cnt % 4 != 0);
        default: m_axis_tready <= (stall_cnt % 6 == 0);
      endcase
    end
  end

  // Monitor: compare every result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (report_q.size() == 0) begin
        $error("result transaction with no prediction pending: %0h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want_rep = report_q.pop_front();
        got_rep  = result_t'(m_axis_tdata[61:0]);
        check_field("accepted", 64'(want_rep.accepted), 64'(got_rep.accepted));
        check_field("packet_done", 64'(want_rep.packet_done), 64'(got_rep.packet_done));
        check_field("packet_bytes", 64'(want_rep.packet_bytes), 64'(got_rep.packet_bytes));
        check_field("byte_count", 64'(want_rep.byte_count), 64'(got_rep.byte_count));
        check_field("overlong", 64'(want_rep.overlong), 64'(got_rep.overlong));
        check_field("pad", 64'd0, 64'(m_axis_tdata[63:62]));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    logic                  f_v;
    logic [1:0]            s_v;
    logic [CFG_DATA_W-1:0] t_v;
    int                    n_v;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: startup seeding, glitch rejects, tick extremes, queue full
    put_raw(116, 1'b1, 1'b0);
    put_raw(116, 1'b1, 1'b0);     // same pin level: rejected
    put_raw(6, 1'b0, 1'b0);       // 3 us: rejected
    put_raw(65535, 1'b0, 1'b1);   // clamped, second seeding edge
    put_raw(0, 1'b1, 1'b0);       // zero length: rejected
    put_raw(16'h5555, 1'b1, 1'b0);
    put_raw(16'hAAAA, 1'b0, 1'b1);
    drain_wait();
    repeat (3) @(posedge clk);
    cfg_write(CFG_FILTER_ENABLE, 11'd0);
    // With the filter off, repeated levels and zero lengths go through
    put_raw(0, 1'b0, 1'b0);
    put_raw(0, 1'b0, 1'b1);
    put_raw(16'hFFFF, 1'b1, 1'b0);
    put_raw(16'h8000, 1'b1, 1'b1);
    put_raw(16'h00FF, 1'b0, 1'b0);
    put_raw(16'h7F00, 1'b1, 1'b0);
    put_raw(2, 1'b0, 1'b1);

    // Random phases across the register settings, extremes included
    for (int p = 0; p < 9; p++) begin
      case (p)
        0:       begin f_v = 1'b1; s_v = STRICT_DECODER;    t_v = 11'd80;   n_v = 180; end
        1:       begin f_v = 1'b1; s_v = STRICT_CONTROLLER; t_v = 11'd80;   n_v = 60;  end
        2:       begin f_v = 1'b0; s_v = STRICT_NONE;       t_v = 11'd80;   n_v = 40;  end
        3:       begin f_v = 1'b1; s_v = STRICT_UNUSED;     t_v = 11'd70;   n_v = 40;  end
        4:       begin f_v = 1'b0; s_v = STRICT_DECODER;    t_v = 11'd1;    n_v = 20;  end
        5:       begin f_v = 1'b1; s_v = STRICT_NONE;       t_v = 11'd1200; n_v = 20;  end
        6:       begin f_v = 1'b1; s_v = STRICT_DECODER;    t_v = 11'd0;    n_v = 15;  end
        7:       begin f_v = 1'b0; s_v = STRICT_CONTROLLER; t_v = 11'd2047; n_v = 20;  end
        default: begin f_v = 1'b1; s_v = STRICT_DECODER;    t_v = 11'd90;   n_v = 40;  end
      endcase
      drain_wait();
      repeat (3) @(posedge clk);
      cfg_write(CFG_FILTER_ENABLE, 11'(f_v));
      cfg_write(CFG_STRICT_MODE, 11'(s_v));
      cfg_write(CFG_ONE_THRESHOLD_US, t_v);
      gen_count = 0;
      gen_limit = n_v;
      // overlong packet
      if (p == 0) put_packet(12, 8, 1'b0);
      while (gen_count < n_v / 2) put_sequence();
      // Pause the sender until everything sent so far has come back
      drain_wait();
      while (gen_count < n_v) put_sequence();
    end

    drain_wait();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
